>>> src/rbf_pkg.sv
// shared types, request and status codes for the ring buffer fifo
`timescale 1ns / 1ps

package rbf_pkg;

   // fixed field widths
   localparam int CNT_W      = 11;
   localparam int ELEM_W     = 32;
   localparam int REQ_W      = 3;
   localparam int STAT_W     = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = 1'b0;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ENQ        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ        = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PUSH_IDX   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_IDX    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
   localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_BURST = 2'd3;

   // classified command as it sits in the queue
   typedef struct packed {
      logic [REQ_W-1:0]  op;
      logic [CNT_W-1:0]  count;
      logic [ELEM_W-1:0] data;
      logic              burst_bad;
      logic              zero_count;
   } cmd_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [CNT_W-1:0] capacity;
      logic             clear;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic [ELEM_W-1:0] elem;
      logic              last;
      logic [CNT_W-1:0]  occupancy;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

endpackage

>>> src/rbf_csr.sv
// capacity register with apb-style write and read access
`timescale 1ns / 1ps

module rbf_csr import rbf_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

   logic [CNT_W-1:0] raw_ff, raw_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] wr_raw;
   logic             wr_cap;

   assign pready = 1'b1;
   assign wr_raw = pwdata[CNT_W-1:0];
   assign wr_cap = psel && penable && pwrite
                   && (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);

   // clamp to the range of usable slots
   always_comb begin
      raw_in = raw_ff;
      cap_in = cap_ff;
      if (wr_cap) begin
         raw_in = wr_raw;
         if (wr_raw == '0) begin
            cap_in = CNT_W'(1);
         end else if (32'(wr_raw) > DEPTH) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = wr_raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= CNT_W'(1024);
         cap_ff <= CNT_W'(CAP_RST);
      end else begin
         raw_ff <= raw_in;
         cap_ff <= cap_in;
      end
   end

   // readback
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) begin
         prdata = CSR_DATA_W'(raw_ff);
      end
   end

   assign cfg.capacity = cap_ff;
   assign cfg.clear    = wr_cap;

endmodule

>>> src/rbf_front.sv
// request intake: classifies each request and queues it for the back end
`timescale 1ns / 1ps

module rbf_front import rbf_pkg::*; #(
   parameter int MAX_BURST = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [CNT_W-1:0]  req_elem_count,
   input  logic [ELEM_W-1:0] req_elem_in,
   input  logic              clearing,
   input  logic              pop,
   output logic              busy,
   output logic              q_empty,
   output cmd_type           cmd
);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              accept;
   cmd_type           new_cmd;

   assign busy    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH)) || clearing;
   assign accept  = start && !busy;
   assign q_empty = (cnt_ff == '0);
   assign cmd     = q_ff[rd_ptr_ff];

   // classify the request on the way in
   always_comb begin
      new_cmd.op         = req_type;
      new_cmd.count      = req_elem_count;
      new_cmd.data       = req_elem_in;
      new_cmd.burst_bad  = (req_elem_count > CNT_W'(MAX_BURST));
      new_cmd.zero_count = (req_elem_count == '0);
   end

   // pointer and fill count
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !accept) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   // fill count stays within the queue
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   // an accepted beat leaves the queue non-empty
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !q_empty)
      else $error("accepted beat lost from queue");

endmodule

>>> src/rbf_back.sv
// execution side: element store, indices, count and result beats
`timescale 1ns / 1ps

module rbf_back import rbf_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int ST_W      = 32,
   parameter int MAX_BURST = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    q_empty,
   output logic    pop,
   output logic    clearing,
   output rsp_type rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int RW = $clog2(MAX_BURST + 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_BURST = 2'd2;

   // index plus step, wrapped at capacity (sum stays below twice capacity)
   function automatic logic [CNT_W-1:0] wrap_add(input logic [CNT_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] s;
      s = {1'b0, idx} + {1'b0, n};
      if (s >= {1'b0, cap}) begin
         s = s - {1'b0, cap};
      end
      return s[CNT_W-1:0];
   endfunction

   logic [ST_W-1:0]   mem [DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [RW-1:0]     rem_ff, rem_in;

   logic              vld_ff, vld_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic              empty_ff, empty_in;
   logic              full_ff, full_in;
   logic              use_mem_ff, use_mem_in;
   logic [ST_W-1:0]   rd_ff;

   logic              we;
   logic [AW-1:0]     wa;
   logic [ST_W-1:0]   wd;
   logic              rd_en;
   logic [AW-1:0]     ra;

   logic [CNT_W-1:0]  cap;
   logic [CNT_W-1:0]  front_inc, front_adv, back_inc, back_adv, total_dec;
   logic [CNT_W:0]    push_sum;

   assign cap       = cfg.capacity;
   assign front_inc = wrap_add(front_ff, CNT_W'(1), cap);
   assign front_adv = wrap_add(front_ff, cmd.count, cap);
   assign back_inc  = wrap_add(back_ff, CNT_W'(1), cap);
   assign back_adv  = wrap_add(back_ff, cmd.count, cap);
   assign total_dec = total_ff - 1'b1;
   assign push_sum  = {1'b0, total_ff} + {1'b0, cmd.count};
   assign clearing  = (state_ff == S_CLEAR);

   // sequencer: clearing pass, single requests and dequeue bursts
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      total_in    = total_ff;
      rem_in      = rem_ff;
      pop         = 1'b0;
      we          = 1'b0;
      wa          = AW'(back_ff);
      wd          = ST_W'(cmd.data);
      rd_en       = 1'b0;
      ra          = AW'(front_ff);
      vld_in      = 1'b0;
      status_in   = ST_OK;
      last_in     = 1'b1;
      occ_in      = total_ff;
      use_mem_in  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            we          = 1'b1;
            wa          = clr_addr_ff;
            wd          = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_RUN;
            end
         end
         S_BURST: begin
            rd_en      = 1'b1;
            front_in   = front_inc;
            total_in   = total_dec;
            occ_in     = total_dec;
            vld_in     = 1'b1;
            use_mem_in = 1'b1;
            last_in    = (rem_ff == RW'(1));
            rem_in     = rem_ff - 1'b1;
            if (rem_ff == RW'(1)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (!q_empty) begin
               pop    = 1'b1;
               vld_in = 1'b1;
               case (cmd.op)
                  REQ_ENQ: begin
                     if (total_ff >= cap) begin
                        status_in = ST_FULL;
                     end else begin
                        we       = 1'b1;
                        back_in  = back_inc;
                        total_in = total_ff + 1'b1;
                        occ_in   = total_ff + 1'b1;
                     end
                  end
                  REQ_DEQ: begin
                     if (cmd.burst_bad) begin
                        status_in = ST_BURST;
                     end else if (cmd.count > total_ff) begin
                        status_in = ST_EMPTY;
                     end else if (!cmd.zero_count) begin
                        // first element of the burst goes out now
                        rd_en      = 1'b1;
                        front_in   = front_inc;
                        total_in   = total_dec;
                        occ_in     = total_dec;
                        use_mem_in = 1'b1;
                        last_in    = (cmd.count == CNT_W'(1));
                        rem_in     = RW'(cmd.count - 1'b1);
                        if (cmd.count != CNT_W'(1)) begin
                           state_in = S_BURST;
                        end
                     end
                  end
                  REQ_PUSH_IDX: begin
                     if (push_sum > {1'b0, cap}) begin
                        status_in = ST_FULL;
                     end else begin
                        total_in = push_sum[CNT_W-1:0];
                        occ_in   = push_sum[CNT_W-1:0];
                        back_in  = back_adv;
                     end
                  end
                  REQ_POP_IDX: begin
                     if (cmd.count > total_ff) begin
                        status_in = ST_EMPTY;
                     end else begin
                        total_in = total_ff - cmd.count;
                        occ_in   = total_ff - cmd.count;
                        front_in = front_adv;
                     end
                  end
                  REQ_PEEK_FRONT: begin
                     rd_en      = 1'b1;
                     use_mem_in = 1'b1;
                  end
                  REQ_PEEK_BACK: begin
                     rd_en      = 1'b1;
                     ra         = AW'(back_ff);
                     use_mem_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase

      // capacity write empties the fifo
      if (cfg.clear) begin
         front_in = '0;
         back_in  = '0;
         total_in = '0;
      end

      empty_in = (occ_in == '0);
      full_in  = (occ_in == cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         front_ff    <= '0;
         back_ff     <= '0;
         total_ff    <= '0;
         rem_ff      <= '0;
         vld_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         front_ff    <= front_in;
         back_ff     <= back_in;
         total_ff    <= total_in;
         rem_ff      <= rem_in;
         vld_ff      <= vld_in;
      end
   end

   // result beat fields
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      last_ff    <= last_in;
      occ_ff     <= occ_in;
      empty_ff   <= empty_in;
      full_ff    <= full_in;
      use_mem_ff <= use_mem_in;
   end

   // element store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_ff <= mem[ra];
      end
   end

   assign rsp.valid     = vld_ff;
   assign rsp.status    = status_ff;
   assign rsp.elem      = use_mem_ff ? ELEM_W'(rd_ff) : '0;
   assign rsp.last      = last_ff;
   assign rsp.occupancy = occ_ff;
   assign rsp.is_empty  = empty_ff;
   assign rsp.is_full   = full_ff;

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= cap)
      else $error("element count above capacity");

   // indices stay inside the ring
   assert property (@(posedge clock) disable iff (reset)
      (front_ff < cap) && (back_ff < cap))
      else $error("index outside capacity");

   // no result beat during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !vld_ff)
      else $error("result beat while clearing");

   // every burst cycle produces a beat
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BURST) |=> vld_ff)
      else $error("burst cycle without result beat");

   // queue is only drained when it holds a command
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop from empty command queue");

endmodule

>>> src/ring_buffer_fifo.sv
// top level of the ring buffer fifo
`timescale 1ns / 1ps

// Circular fifo with enqueue, burst dequeue, index push/pop and peek requests.
// Requests: a beat is taken at a rising edge with start high and busy low;
// req_type selects the operation, req_elem_count and req_elem_in its operands.
// Results: each beat is on the rsp_ ports for one cycle while rsp_valid is high,
// the receiver cannot hold them off; rsp_last marks the final beat of a request.
// Order: an accepted request is written into the command queue; when the back end
// is free it takes the request and registers the first result beat.
// Throughput: one request per cycle for enqueue, push, pop and peek while no
// burst drains and busy is low; a dequeue gives one beat per cycle, set by the
// single read port of the element store. A four-entry command queue lets
// requests arrive while a burst drains; busy rises when it is full.
// Reset: a clearing pass zeroes the element store with busy high; capacity
// writes are taken meanwhile. A capacity write empties the fifo but leaves the
// stored elements alone. Configure only while idle.
module ring_buffer_fifo import rbf_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int ELEM_BITS = 32,
   parameter int MAX_BURST = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [CNT_W-1:0]      req_elem_count,
   input  logic [ELEM_W-1:0]     req_elem_in,
   output logic                  rsp_valid,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [ELEM_W-1:0]     rsp_elem_out,
   output logic                  rsp_last,
   output logic [CNT_W-1:0]      rsp_occupancy,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ST_W = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;

   cfg_type cfg;
   cmd_type cmd;
   rsp_type rsp;
   logic    q_empty;
   logic    pop;
   logic    clearing;

   // configuration register
   rbf_csr #(
      .DEPTH(DEPTH)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   // request intake and command queue
   rbf_front #(
      .MAX_BURST(MAX_BURST)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_type      (req_type),
      .req_elem_count(req_elem_count),
      .req_elem_in   (req_elem_in),
      .clearing      (clearing),
      .pop           (pop),
      .busy          (busy),
      .q_empty       (q_empty),
      .cmd           (cmd)
   );

   // execution and element store
   rbf_back #(
      .DEPTH    (DEPTH),
      .ST_W     (ST_W),
      .MAX_BURST(MAX_BURST)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .q_empty (q_empty),
      .pop     (pop),
      .clearing(clearing),
      .rsp     (rsp)
   );

   assign rsp_valid     = rsp.valid;
   assign rsp_status    = rsp.status;
   assign rsp_elem_out  = rsp.elem;
   assign rsp_last      = rsp.last;
   assign rsp_occupancy = rsp.occupancy;
   assign rsp_is_empty  = rsp.is_empty;
   assign rsp_is_full   = rsp.is_full;

endmodule

>>> sim/rbf_result_checker.sv
// result checker for the ring buffer fifo: tracks the fifo state and compares every result beat
`timescale 1ns / 1ps

module rbf_result_checker import rbf_pkg::*; #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [CNT_W-1:0]      req_elem_count,
   input  logic [ELEM_W-1:0]     req_elem_in,
   input  logic                  rsp_valid,
   input  logic [STAT_W-1:0]     rsp_status,
   input  logic [ELEM_W-1:0]     rsp_elem_out,
   input  logic                  rsp_last,
   input  logic [CNT_W-1:0]      rsp_occupancy,
   input  logic                  rsp_is_empty,
   input  logic                  rsp_is_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    beats_due
);

   // one predicted result beat
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ELEM_W-1:0] elem;
      logic              last;
      logic [CNT_W-1:0]  occupancy;
      logic              is_empty;
      logic              is_full;
   } fifo_beat_type;

   fifo_beat_type     pending_beats[$];
   logic [ELEM_W-1:0] slot_copy[DEPTH];
   int                front_pos;
   int                back_pos;
   int                held;
   int                slots;
   int                errors;

   assign fail_count = errors;

   // queue one predicted beat, flags taken from the current occupancy
   function automatic void add_beat(logic [STAT_W-1:0] st, logic [ELEM_W-1:0] value,
                                    logic lst);
      fifo_beat_type b;
      b.status    = st;
      b.elem      = value;
      b.last      = lst;
      b.occupancy = CNT_W'(held);
      b.is_empty  = (held == 0);
      b.is_full   = (held == slots);
      pending_beats.push_back(b);
   endfunction

   // new capacity, clamped to 1..DEPTH, empties the fifo but keeps the slots
   function automatic void set_capacity(logic [CSR_DATA_W-1:0] value);
      int v;
      v = int'(value[CNT_W-1:0]);
      if (v == 0) slots = 1;
      else if (v > DEPTH) slots = DEPTH;
      else slots = v;
      front_pos = 0;
      back_pos = 0;
      held = 0;
   endfunction

   // advance the fifo by one request and predict its beats
   function automatic void fifo_request(logic [REQ_W-1:0] op, logic [CNT_W-1:0] cnt,
                                        logic [ELEM_W-1:0] data);
      int n;
      n = int'(cnt);
      case (op)
         REQ_ENQ: begin
            if (held >= slots) begin
               add_beat(ST_FULL, '0, 1'b1);
            end else begin
               slot_copy[back_pos] = data;
               back_pos = (back_pos + 1) % slots;
               held++;
               add_beat(ST_OK, '0, 1'b1);
            end
         end
         REQ_DEQ: begin
            if (n > MAX_BURST) begin
               add_beat(ST_BURST, '0, 1'b1);
            end else if (n > held) begin
               add_beat(ST_EMPTY, '0, 1'b1);
            end else if (n == 0) begin
               add_beat(ST_OK, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  logic [ELEM_W-1:0] v;
                  v = slot_copy[front_pos];
                  front_pos = (front_pos + 1) % slots;
                  held--;
                  add_beat(ST_OK, v, i == n - 1);
               end
            end
         end
         REQ_PUSH_IDX: begin
            if (held + n > slots) begin
               add_beat(ST_FULL, '0, 1'b1);
            end else begin
               held += n;
               back_pos = (back_pos + n) % slots;
               add_beat(ST_OK, '0, 1'b1);
            end
         end
         REQ_POP_IDX: begin
            if (n > held) begin
               add_beat(ST_EMPTY, '0, 1'b1);
            end else begin
               held -= n;
               front_pos = (front_pos + n) % slots;
               add_beat(ST_OK, '0, 1'b1);
            end
         end
         REQ_PEEK_FRONT: add_beat(ST_OK, slot_copy[front_pos], 1'b1);
         REQ_PEEK_BACK:  add_beat(ST_OK, slot_copy[back_pos], 1'b1);
         default:        add_beat(ST_OK, '0, 1'b1);
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // watch the three ports at every rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) slot_copy[i] = '0;
         pending_beats.delete();
         front_pos = 0;
         back_pos = 0;
         held = 0;
         slots = (DEPTH < 1024) ? DEPTH : 1024;
         errors = 0;
      end else begin
         // register write
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == REG_CAPACITY)
            set_capacity(pwdata);

         // accepted request beat
         if (start && !busy)
            fifo_request(req_type, req_elem_count, req_elem_in);

         // result beat against the oldest prediction
         if (rsp_valid) begin
            if (pending_beats.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected, status %0h elem %0h",
                        $time, rsp_status, rsp_elem_out);
            end else begin
               fifo_beat_type b;
               b = pending_beats.pop_front();
               check_field("status", 32'(b.status), 32'(rsp_status));
               check_field("elem_out", 32'(b.elem), 32'(rsp_elem_out));
               check_field("last", 32'(b.last), 32'(rsp_last));
               check_field("occupancy", 32'(b.occupancy), 32'(rsp_occupancy));
               check_field("is_empty", 32'(b.is_empty), 32'(rsp_is_empty));
               check_field("is_full", 32'(b.is_full), 32'(rsp_is_full));
            end
         end
      end
      beats_due <= pending_beats.size();
   end

endmodule

>>> sim/ring_buffer_fifo_tb.sv
// testbench top for the ring buffer fifo: request and register stimulus, verdict
`timescale 1ns / 1ps

module ring_buffer_fifo_tb import rbf_pkg::*;;

   localparam int DEPTH     = 1024;
   localparam int ELEM_BITS = 32;
   localparam int MAX_BURST = 64;

   // request codes the block ignores
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

   // register addresses
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic [REQ_W-1:0]      req_type       = '0;
   logic [CNT_W-1:0]      req_elem_count = '0;
   logic [ELEM_W-1:0]     req_elem_in    = '0;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;

   logic                  busy;
   logic                  rsp_valid;
   logic [STAT_W-1:0]     rsp_status;
   logic [ELEM_W-1:0]     rsp_elem_out;
   logic                  rsp_last;
   logic [CNT_W-1:0]      rsp_occupancy;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int beats_due;
   bit calm = 1'b0;

   ring_buffer_fifo #(
      .DEPTH(DEPTH), .ELEM_BITS(ELEM_BITS), .MAX_BURST(MAX_BURST)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_elem_count(req_elem_count), .req_elem_in(req_elem_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_elem_out(rsp_elem_out),
      .rsp_last(rsp_last), .rsp_occupancy(rsp_occupancy), .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   rbf_result_checker #(.DEPTH(DEPTH), .MAX_BURST(MAX_BURST)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_elem_count(req_elem_count), .req_elem_in(req_elem_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_elem_out(rsp_elem_out),
      .rsp_last(rsp_last), .rsp_occupancy(rsp_occupancy), .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .beats_due(beats_due)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // hold one request beat until the block takes it
   task automatic send_req(logic [REQ_W-1:0] op, logic [CNT_W-1:0] cnt,
                           logic [ELEM_W-1:0] data);
      start <= 1'b1;
      req_type <= op;
      req_elem_count <= cnt;
      req_elem_in <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // start low while junk goes on the request fields
   task automatic rest(int cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_type <= REQ_W'($urandom);
         req_elem_count <= CNT_W'($urandom);
         req_elem_in <= $urandom;
         @(posedge clock);
      end
   endtask

   // random idle bursts, with quiet stretches in between
   task automatic maybe_rest();
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (!calm && $urandom_range(0, 2) == 0) rest($urandom_range(1, 12));
   endtask

   // wait until every result is out before touching the register
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // one random request shaped by the capacity in force
   task automatic send_random(int cap);
      int pick;
      int span;
      logic [REQ_W-1:0] op;
      logic [CNT_W-1:0] cnt;
      pick = $urandom_range(0, 99);
      span = (cap < MAX_BURST) ? cap : MAX_BURST;
      cnt = CNT_W'($urandom_range(0, (span < 6) ? span : 6));
      if (pick < 36) begin
         op = REQ_ENQ;
      end else if (pick < 60) begin
         op = REQ_DEQ;
         if ($urandom_range(0, 6) == 0) cnt = CNT_W'($urandom_range(0, span));
         if ($urandom_range(0, 19) == 0) cnt = CNT_W'($urandom_range(MAX_BURST + 1, 2047));
      end else if (pick < 72) begin
         op = REQ_PUSH_IDX;
         if ($urandom_range(0, 5) == 0) cnt = CNT_W'($urandom_range(0, cap));
         if ($urandom_range(0, 19) == 0) cnt = CNT_W'($urandom);
      end else if (pick < 84) begin
         op = REQ_POP_IDX;
         if ($urandom_range(0, 5) == 0) cnt = CNT_W'($urandom_range(0, cap));
         if ($urandom_range(0, 19) == 0) cnt = CNT_W'($urandom);
      end else if (pick < 90) begin
         op = REQ_PEEK_FRONT;
      end else if (pick < 96) begin
         op = REQ_PEEK_BACK;
      end else begin
         op = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
         cnt = CNT_W'($urandom);
      end
      send_req(op, cnt, $urandom);
   endtask

   // capacity settings per phase, raw register values
   int cap_plan[11] = '{1, 0, 2, 5, 16, 2047, 1023, 7, 1100, 3, 1024};

   initial begin
      int raw;
      int cap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, zero length, burst too long, full, wrap via index moves
      send_req(REQ_PEEK_FRONT, '0, $urandom);
      send_req(REQ_PEEK_BACK, '0, $urandom);
      send_req(REQ_DEQ, 11'd1, '0);
      send_req(REQ_DEQ, 11'd0, '0);
      send_req(REQ_DEQ, 11'(MAX_BURST + 1), '0);
      send_req(REQ_DEQ, 11'd2047, '0);
      send_req(REQ_POP_IDX, 11'd1, '0);
      send_req(REQ_POP_IDX, 11'd0, '0);
      send_req(REQ_ENQ, 11'd2047, 32'h0000_0000);
      send_req(REQ_ENQ, '0, 32'hFFFF_FFFF);
      rest(3);
      send_req(REQ_ENQ, '0, 32'hA5A5_5A5A);
      send_req(REQ_PEEK_FRONT, '0, '0);
      send_req(REQ_PEEK_BACK, '0, '0);
      send_req(REQ_DEQ, 11'd3, '0);
      send_req(REQ_SPARE_A, 11'd2047, 32'hFFFF_FFFF);
      send_req(REQ_SPARE_B, 11'd5, $urandom);
      send_req(REQ_PUSH_IDX, 11'd2047, '0);
      send_req(REQ_PUSH_IDX, 11'(DEPTH), '0);
      send_req(REQ_ENQ, '0, $urandom);
      send_req(REQ_PUSH_IDX, 11'd0, '0);
      send_req(REQ_DEQ, 11'(MAX_BURST), '0);
      rest(2);
      send_req(REQ_POP_IDX, 11'(DEPTH - MAX_BURST), '0);
      send_req(REQ_POP_IDX, 11'd2047, '0);
      send_req(REQ_ENQ, '0, $urandom);
      send_req(REQ_DEQ, 11'd1, '0);

      // write to an unused address must leave the fifo alone
      settle();
      write_csr(SPARE_ADDR, $urandom);
      cap = DEPTH;
      for (int i = 0; i < 6; i++) begin
         maybe_rest();
         send_random(cap);
      end

      // random phases, one capacity each
      foreach (cap_plan[p]) begin
         settle();
         raw = cap_plan[p];
         write_csr(CAP_ADDR, {21'($urandom), 11'(raw)});
         cap = (raw == 0) ? 1 : ((raw > DEPTH) ? DEPTH : raw);
         if (p == $size(cap_plan) - 1) calm = 1'b1;
         for (int i = 0; i < 23; i++) begin
            if (p != $size(cap_plan) - 1) maybe_rest();
            send_random(cap);
         end
      end

      // drain
      start <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && beats_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
